// ===== hdl/cd_pkg.sv =====
package cd_pkg;

  // Store geometry
  localparam int DEPTH  = 8;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  // Operation codes carried by cmd
  typedef enum logic [1:0] {
    CMD_INS_FRONT = 2'd0,
    CMD_INS_REAR  = 2'd1,
    CMD_DEL_FRONT = 2'd2,
    CMD_DEL_REAR  = 2'd3
  } cmd_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_READ   = 2'd1,
    S_RESULT = 2'd2
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic exec;   // apply the operation on the input beat
    logic rd;     // fetch front and rear words from the store
  } cd_ctl_t;

endpackage

// ===== hdl/cd_ctrl.sv =====
module cd_ctrl
  import cd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output cd_ctl_t ctl
);

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctl.exec   = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        ctl.rd     = 1'b1;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/cd_datapath.sv =====
module cd_datapath
  import cd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  cd_ctl_t                  ctl,
  input  logic [1:0]               cmd,
  input  logic signed [DATA_W-1:0] value,
  output logic [1:0]               status,
  output logic [CNT_W-1:0]         count,
  output logic                     is_empty,
  output logic                     is_full,
  output logic signed [DATA_W-1:0] front_value,
  output logic signed [DATA_W-1:0] rear_value
);

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rd_front;
  logic signed [DATA_W-1:0] rd_rear;

  logic [IDX_W-1:0] front_index, front_index_next;
  logic [IDX_W-1:0] rear_index, rear_index_next;
  logic [CNT_W-1:0] held_count, held_count_next;
  status_t          status_q, status_next;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic             cur_empty, cur_full, is_ins;
  logic [IDX_W-1:0] front_prev, front_inc, rear_prev, rear_inc;

  // Circular index neighbors
  always_comb begin
    front_inc  = (front_index == IDX_W'(DEPTH - 1)) ? '0 : front_index + 1'b1;
    front_prev = (front_index == '0) ? IDX_W'(DEPTH - 1) : front_index - 1'b1;
    rear_inc   = (rear_index == IDX_W'(DEPTH - 1)) ? '0 : rear_index + 1'b1;
    rear_prev  = (rear_index == '0) ? IDX_W'(DEPTH - 1) : rear_index - 1'b1;
  end

  // Operation decode and next pointer values
  always_comb begin
    cur_empty        = (held_count == '0);
    cur_full         = (held_count == CNT_W'(DEPTH));
    is_ins           = (cmd == CMD_INS_FRONT) || (cmd == CMD_INS_REAR);
    front_index_next = front_index;
    rear_index_next  = rear_index;
    held_count_next  = held_count;
    status_next      = ST_DONE;
    wr_en            = 1'b0;
    wr_addr          = '0;
    if (is_ins) begin
      if (cur_full) begin
        status_next = ST_FULL;
      end else if (cur_empty) begin
        // first entry always lands in slot zero
        front_index_next = '0;
        rear_index_next  = '0;
        held_count_next  = CNT_W'(1);
        wr_en            = 1'b1;
        wr_addr          = '0;
      end else if (cmd == CMD_INS_FRONT) begin
        front_index_next = front_prev;
        held_count_next  = held_count + 1'b1;
        wr_en            = 1'b1;
        wr_addr          = front_prev;
      end else begin
        rear_index_next = rear_inc;
        held_count_next = held_count + 1'b1;
        wr_en           = 1'b1;
        wr_addr         = rear_inc;
      end
    end else begin
      if (cur_empty) begin
        status_next = ST_EMPTY;
      end else if (held_count == CNT_W'(1)) begin
        // last entry removed: pointers return home
        front_index_next = '0;
        rear_index_next  = '0;
        held_count_next  = '0;
      end else if (cmd == CMD_DEL_FRONT) begin
        front_index_next = front_inc;
        held_count_next  = held_count - 1'b1;
      end else begin
        rear_index_next = rear_prev;
        held_count_next = held_count - 1'b1;
      end
    end
  end

  // Pointer and count registers
  always_ff @(posedge clk) begin
    if (rst) begin
      front_index <= '0;
      rear_index  <= '0;
      held_count  <= '0;
    end else if (ctl.exec) begin
      front_index <= front_index_next;
      rear_index  <= rear_index_next;
      held_count  <= held_count_next;
    end
  end

  // Status of the last operation
  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      status_q <= status_next;
    end
  end

  // Entry store: one write port
  always_ff @(posedge clk) begin
    if (ctl.exec && wr_en) begin
      mem[wr_addr] <= value;
    end
  end

  // Entry store: two registered read ports
  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rd_front <= mem[front_index];
      rd_rear  <= mem[rear_index];
    end
  end

  // Result fields
  assign status      = status_q;
  assign count       = held_count;
  assign is_empty    = (held_count == '0);
  assign is_full     = (held_count == CNT_W'(DEPTH));
  assign front_value = is_empty ? '0 : rd_front;
  assign rear_value  = is_empty ? '0 : rd_rear;

endmodule

// ===== hdl/circular_deque.sv =====
// Channel  | Handshake            | Beat contents
// ---------+----------------------+---------------------------------------------
// input    | in_valid / in_stall  | cmd, value
// output   | out_valid / out_stall| status, count, is_empty, is_full,
//          |                      | front_value, rear_value
//
// One operation at a time: accept, store access, result. The result beat
// is held while out_stall is high; the next item is taken the cycle after
// the result leaves.
// The two-read-port entry store sets the read cycle between update and result.
// Reset (rst, synchronous) empties the deque; store words are not cleared.
// in_stall is high whenever an operation is in flight.
module circular_deque
  import cd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               cmd,
  input  logic signed [DATA_W-1:0] value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               status,
  output logic [CNT_W-1:0]         count,
  output logic                     is_empty,
  output logic                     is_full,
  output logic signed [DATA_W-1:0] front_value,
  output logic signed [DATA_W-1:0] rear_value
);

  cd_ctl_t ctl;

  cd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl)
  );

  cd_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .cmd         (cmd),
    .value       (value),
    .status      (status),
    .count       (count),
    .is_empty    (is_empty),
    .is_full     (is_full),
    .front_value (front_value),
    .rear_value  (rear_value)
  );

endmodule

// ===== hdl/cd_checker.sv =====
module cd_checker
  import cd_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [1:0]               status,
  input logic [CNT_W-1:0]         count,
  input logic                     is_empty,
  input logic                     is_full,
  input logic signed [DATA_W-1:0] front_value,
  input logic signed [DATA_W-1:0] rear_value
);

  // Flags agree with the count on every result beat
  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_empty == (count == '0)) && (is_full == (count == CNT_W'(DEPTH))))
    else $error("empty/full flags disagree with count");

  // An empty deque shows zero front and rear words
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_empty |-> (front_value == '0) && (rear_value == '0))
    else $error("empty deque shows nonzero front or rear");

  // A rejected removal leaves the deque empty, a rejected insert leaves it full
  a_reject: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((status != ST_EMPTY) || is_empty) && ((status != ST_FULL) || is_full))
    else $error("rejection status inconsistent with occupancy");

  // Only one operation in flight: no input accepted right after one
  a_single: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item accepted while one is in flight");

  // A stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(count)
      && $stable(front_value) && $stable(rear_value))
    else $error("stalled result beat changed");

endmodule

bind circular_deque cd_checker u_cd_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .status      (status),
  .count       (count),
  .is_empty    (is_empty),
  .is_full     (is_full),
  .front_value (front_value),
  .rear_value  (rear_value)
);

// ===== verif/tb_circular_deque.sv =====
`timescale 1ns / 1ps

module tb_circular_deque;
  import cd_pkg::*;

  // One result beat as the deque should report it
  typedef struct {
    status_t                   st;
    logic [CNT_W-1:0]          cnt;
    logic                      emp;
    logic                      ful;
    logic signed [DATA_W-1:0]  fv;
    logic signed [DATA_W-1:0]  rv;
  } deque_result_t;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  logic [1:0]                cmd;
  logic signed [DATA_W-1:0]  value;
  logic                      out_valid;
  logic                      out_stall;
  logic [1:0]                status;
  logic [CNT_W-1:0]          count;
  logic                      is_empty;
  logic                      is_full;
  logic signed [DATA_W-1:0]  front_value;
  logic signed [DATA_W-1:0]  rear_value;

  circular_deque i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .count       (count),
    .is_empty    (is_empty),
    .is_full     (is_full),
    .front_value (front_value),
    .rear_value  (rear_value)
  );

  // Shadow deque
  logic signed [DATA_W-1:0] shadow_words [DEPTH];
  int shadow_head;
  int shadow_tail;
  int shadow_count;
  deque_result_t pending_results [$];

  // Run bookkeeping
  bit idle_on;
  int error_count;
  int ops_sent;
  int beats_checked;
  int full_rejects;
  int empty_rejects;
  int full_hits;

  // 10 ns clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Apply one operation to the shadow deque and queue the result it should give
  function automatic void shadow_apply(cmd_t op, logic signed [DATA_W-1:0] word);
    deque_result_t r;
    r.st = ST_DONE;
    if (op == CMD_INS_FRONT || op == CMD_INS_REAR) begin
      if (shadow_count == DEPTH) begin
        r.st = ST_FULL;
      end else if (shadow_count == 0) begin
        // first word always lands in entry 0
        shadow_head = 0;
        shadow_tail = 0;
        shadow_words[0] = word;
        shadow_count = 1;
      end else if (op == CMD_INS_FRONT) begin
        shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
        shadow_words[shadow_head] = word;
        shadow_count++;
      end else begin
        shadow_tail = (shadow_tail + 1) % DEPTH;
        shadow_words[shadow_tail] = word;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        r.st = ST_EMPTY;
      end else if (shadow_count == 1) begin
        // last entry gone: both pointers back to 0
        shadow_head = 0;
        shadow_tail = 0;
        shadow_count = 0;
      end else if (op == CMD_DEL_FRONT) begin
        shadow_head = (shadow_head + 1) % DEPTH;
        shadow_count--;
      end else begin
        shadow_tail = (shadow_tail + DEPTH - 1) % DEPTH;
        shadow_count--;
      end
    end
    r.cnt = CNT_W'(shadow_count);
    r.emp = (shadow_count == 0);
    r.ful = (shadow_count == DEPTH);
    r.fv  = r.emp ? '0 : shadow_words[shadow_head];
    r.rv  = r.emp ? '0 : shadow_words[shadow_tail];
    if (r.st == ST_FULL) full_rejects++;
    if (r.st == ST_EMPTY) empty_rejects++;
    if (r.ful && r.st == ST_DONE) full_hits++;
    pending_results.push_back(r);
  endfunction

  // One line per mismatch
  task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                 logic [DATA_W-1:0] want);
    error_count++;
    $display("[%0t] beat %0d %s: got 0x%0h, expected 0x%0h",
             $realtime, beats_checked, what, got, want);
  endtask

  // Send one operation beat; valid stays high between back-to-back beats
  task automatic send_op(cmd_t op, logic signed [DATA_W-1:0] word);
    int gap;
    gap = idle_on ? $urandom_range(0, 9) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= op;
    value    <= word;
    do @(posedge clk); while (in_stall);
    shadow_apply(op, word);
    ops_sent++;
  endtask

  // Result side back-pressure, redrawn for every beat taken
  initial begin
    int hold;
    out_stall = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      hold = idle_on ? $urandom_range(0, 9) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // Compare each accepted result beat with the oldest pending one
  always @(posedge clk) begin
    deque_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat, status", DATA_W'(status), '0);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.st)
          report_mismatch("status", DATA_W'(status), DATA_W'(want.st));
        if (count !== want.cnt)
          report_mismatch("count", DATA_W'(count), DATA_W'(want.cnt));
        if (is_empty !== want.emp)
          report_mismatch("is_empty", DATA_W'(is_empty), DATA_W'(want.emp));
        if (is_full !== want.ful)
          report_mismatch("is_full", DATA_W'(is_full), DATA_W'(want.ful));
        if (front_value !== want.fv) report_mismatch("front_value", front_value, want.fv);
        if (rear_value !== want.rv)  report_mismatch("rear_value", rear_value, want.rv);
      end
      beats_checked++;
    end
  end

  // Removals right after reset must be refused
  task automatic test_empty_removals();
    send_op(CMD_DEL_FRONT, 32'sd0);
    send_op(CMD_DEL_REAR, -32'sd1);
  endtask

  // Extreme words at both ends, down to removing the last entry
  task automatic test_value_extremes();
    send_op(CMD_INS_REAR, 32'sh7fff_ffff);
    send_op(CMD_INS_FRONT, 32'sh8000_0000);
    send_op(CMD_INS_REAR, -32'sd1);
    send_op(CMD_DEL_FRONT, 32'sh7fff_ffff);
    send_op(CMD_DEL_REAR, 32'sh8000_0000);
    send_op(CMD_DEL_REAR, 32'sd0);
  endtask

  // Fill from both ends past full, then drain past empty
  task automatic test_fill_and_overflow();
    for (int i = 0; i < DEPTH; i++)
      send_op((i % 2) ? CMD_INS_FRONT : CMD_INS_REAR, $urandom);
    send_op(CMD_INS_FRONT, 32'sh5555_5555);
    send_op(CMD_INS_REAR, 32'shaaaa_aaaa);
    for (int i = 0; i < DEPTH; i++)
      send_op((i % 2) ? CMD_DEL_REAR : CMD_DEL_FRONT, $urandom);
    send_op(CMD_DEL_FRONT, 32'sd0);
  endtask

  // Bursts that lean toward filling or draining, so full and empty recur
  task automatic test_random_ops(int n_ops);
    int lean;
    int kind;
    logic signed [DATA_W-1:0] word;
    cmd_t op;
    for (int i = 0; i < n_ops; i++) begin
      if (i % 40 == 0) begin
        lean    = $urandom_range(15, 85);
        idle_on = ($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(1, 100) <= lean)
        op = $urandom_range(0, 1) ? CMD_INS_REAR : CMD_INS_FRONT;
      else
        op = $urandom_range(0, 1) ? CMD_DEL_REAR : CMD_DEL_FRONT;
      kind = $urandom_range(0, 11);
      case (kind)
        0: word = 32'sh7fff_ffff;
        1: word = 32'sh8000_0000;
        2: word = -32'sd1;
        3: word = 32'sd0;
        default: word = $urandom;
      endcase
      send_op(op, word);
    end
  endtask

  // Test sequence
  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    cmd           = CMD_INS_FRONT;
    value         = '0;
    idle_on       = 1'b1;
    error_count   = 0;
    ops_sent      = 0;
    beats_checked = 0;
    full_rejects  = 0;
    empty_rejects = 0;
    full_hits     = 0;
    shadow_head   = 0;
    shadow_tail   = 0;
    shadow_count  = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_removals();
    test_value_extremes();
    test_fill_and_overflow();
    test_random_ops(1800);

    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (10) @(posedge clk);

    $display("ran %0d operations, checked %0d result beats", ops_sent, beats_checked);
    $display("deque filled %0d times; %0d full and %0d empty rejections",
             full_hits, full_rejects, empty_rejects);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("circular_deque: match");
    end else begin
      $display("circular_deque: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("timeout with %0d beats still pending", pending_results.size());
    $display("circular_deque: mismatch");
    $finish;
  end

endmodule
